>>> sv/sftr_pkg.sv
package sftr_pkg;

   localparam int SCREEN_WIDTH_DEF  = 84;
   localparam int SCREEN_HEIGHT_DEF = 48;
   localparam int MAX_SCALE_DEF     = 6;

   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_COUNT = 96;
   localparam int GLYPH_FIRST = 32;

   localparam logic [2:0] OP_CLEAR      = 3'd0;
   localparam logic [2:0] OP_SET_PIXEL  = 3'd1;
   localparam logic [2:0] OP_DRAW_CHAR  = 3'd2;
   localparam logic [2:0] OP_SET_CURSOR = 3'd3;
   localparam logic [2:0] OP_READ_BYTE  = 3'd4;

   typedef struct packed {
      logic [2:0] operation;
      logic [6:0] char_code;
      logic [2:0] char_scale;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic       pixel_on;
      logic [8:0] byte_index;
   } sftr_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
   } sftr_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_GLY_INIT,
      ST_GLY_RD,
      ST_GLY_WR,
      ST_GLY_END,
      ST_BYTE_RD,
      ST_BYTE_WAIT,
      ST_RESP
   } sftr_state_type;

   // Column bytes of each glyph, leftmost column in the top byte; bit 0 is the top row.
   localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
   };

endpackage

>>> sv/sftr_ram.sv
module sftr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 504
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/scaled_font_text_renderer.sv
// Every operation ends in ST_RESP, which registers the response. A draw-character word
// reads and rewrites (ST_GLY_RD, ST_GLY_WR) each framebuffer byte touched, per column and page;
// clipped glyphs touch fewer bytes. One word at a time: a new word is taken only in ST_IDLE.
// Reset (synchronous, active high) homes the cursor and sweeps zeros through the frame
// store, one byte a cycle, with req_stall held high.
module scaled_font_text_renderer #(
   parameter int SCREEN_WIDTH  = sftr_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sftr_pkg::SCREEN_HEIGHT_DEF,
   parameter int MAX_SCALE     = sftr_pkg::MAX_SCALE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sftr_pkg::sftr_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sftr_pkg::sftr_rsp_type rsp_data
);

   localparam int FB_PAGES = (SCREEN_HEIGHT + 7) / 8;
   localparam int FB_BYTES = SCREEN_WIDTH * FB_PAGES;
   localparam int AW       = $clog2(FB_BYTES + 1);
   localparam int SW       = $clog2(MAX_SCALE + 1);
   localparam int EL       = sftr_pkg::GLYPH_ROWS * MAX_SCALE;
   localparam int QW       = EL + 16;

   sftr_pkg::sftr_state_type state_ff, state_in;
   sftr_pkg::sftr_req_type   req_ff, req_in;
   sftr_pkg::sftr_rsp_type   rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [7:0]    cursor_x_ff, cursor_x_in;
   logic [7:0]    cursor_y_ff, cursor_y_in;
   logic [7:0]    res_rd_ff, res_rd_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_resp_ff, clr_resp_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [SW-1:0] scale_ff, scale_in;
   logic [39:0]   glyph_ff, glyph_in;
   logic [2:0]    gc_ff, gc_in;
   logic [SW-1:0] sub_ff, sub_in;
   logic [8:0]    col_x_ff, col_x_in;
   logic [8:0]    py_base_ff, py_base_in;
   logic [8:0]    first_py_ff, first_py_in;
   logic [7:0]    last_row_ff, last_row_in;
   logic [AW-1:0] page_addr_ff, page_addr_in;
   logic [AW-1:0] first_page_ff, first_page_in;
   logic [7:0]    win_ff, win_in;
   logic [7:0]    mask_ff, mask_in;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   logic [SW-1:0] req_scale;
   logic [7:0]    col_bits;
   logic [EL-1:0] exp_col;
   logic [EL-1:0] cov_col;
   logic [EL-1:0] rep_mask;
   logic [QW-1:0] exp_pad;
   logic [QW-1:0] cov_pad;
   logic [9:0]    win_shift;
   logic [7:0]    h_mask;
   logic [9:0]    next_x;
   logic [9:0]    next_y;
   logic [9:0]    last_row_wide;
   logic [6:0]    glyph_idx;

   sftr_ram #(
      .WIDTH (8),
      .DEPTH (FB_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr[$clog2(FB_BYTES)-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr[$clog2(FB_BYTES)-1:0]),
      .rd_data (mem_rd_data)
   );

   // Scale clamp and glyph lookup for the incoming word.
   always_comb begin
      if (req_data.char_scale == 3'd0) begin
         req_scale = SW'(1);
      end else if (32'(req_data.char_scale) > MAX_SCALE) begin
         req_scale = SW'(MAX_SCALE);
      end else begin
         req_scale = SW'(req_data.char_scale);
      end
      glyph_idx = 7'(req_data.char_code - 7'(sftr_pkg::GLYPH_FIRST));
   end

   // Expand the current glyph column vertically by the scale, then cut out one page.
   always_comb begin
      col_bits = glyph_ff[(sftr_pkg::GLYPH_COLS - 1 - 32'(gc_ff)) * 8 +: 8];
      rep_mask = ~({EL{1'b1}} << scale_ff);
      exp_col  = '0;
      for (int g = 0; g < sftr_pkg::GLYPH_ROWS; g++) begin
         if (col_bits[g]) begin
            exp_col = exp_col | (rep_mask << (g * 32'(scale_ff)));
         end
      end
      cov_col   = ~({EL{1'b1}} << (sftr_pkg::GLYPH_ROWS * 32'(scale_ff)));
      exp_pad   = {8'd0, exp_col, 8'd0};
      cov_pad   = {8'd0, cov_col, 8'd0};
      win_shift = 10'(py_base_ff) + 10'd8 - 10'(cursor_y_ff);
      for (int k = 0; k < 8; k++) begin
         h_mask[k] = (10'(py_base_ff) + 10'(k)) < 10'(SCREEN_HEIGHT);
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      res_rd_in     = res_rd_ff;
      clr_addr_in   = clr_addr_ff;
      clr_resp_in   = clr_resp_ff;
      addr_in       = addr_ff;
      scale_in      = scale_ff;
      glyph_in      = glyph_ff;
      gc_in         = gc_ff;
      sub_in        = sub_ff;
      col_x_in      = col_x_ff;
      py_base_in    = py_base_ff;
      first_py_in   = first_py_ff;
      last_row_in   = last_row_ff;
      page_addr_in  = page_addr_ff;
      first_page_in = first_page_ff;
      win_in        = win_ff;
      mask_in       = mask_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_ff;
      req_stall     = 1'b1;
      next_x        = '0;
      next_y        = '0;
      last_row_wide = '0;

      case (state_ff)
         sftr_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            clr_addr_in = AW'(clr_addr_ff + 1'b1);
            if (32'(clr_addr_ff) == FB_BYTES - 1) begin
               state_in = clr_resp_ff ? sftr_pkg::ST_RESP : sftr_pkg::ST_IDLE;
            end
         end

         sftr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in    = req_data;
               res_rd_in = '0;
               case (req_data.operation)
                  sftr_pkg::OP_CLEAR: begin
                     cursor_x_in = '0;
                     cursor_y_in = '0;
                     clr_addr_in = '0;
                     clr_resp_in = 1'b1;
                     state_in    = sftr_pkg::ST_CLEAR;
                  end
                  sftr_pkg::OP_SET_PIXEL: begin
                     addr_in = AW'(32'(req_data.y_pos[7:3]) * SCREEN_WIDTH
                                   + 32'(req_data.x_pos));
                     if (32'(req_data.x_pos) < SCREEN_WIDTH &&
                         32'(req_data.y_pos) < SCREEN_HEIGHT) begin
                        state_in = sftr_pkg::ST_PIX_RD;
                     end else begin
                        state_in = sftr_pkg::ST_RESP;
                     end
                  end
                  sftr_pkg::OP_DRAW_CHAR: begin
                     scale_in = req_scale;
                     if (req_data.char_code >= 7'(sftr_pkg::GLYPH_FIRST)) begin
                        glyph_in = sftr_pkg::GLYPH_ROM[glyph_idx];
                     end else begin
                        glyph_in = '0;
                     end
                     state_in = sftr_pkg::ST_GLY_INIT;
                  end
                  sftr_pkg::OP_SET_CURSOR: begin
                     cursor_x_in = req_data.x_pos;
                     cursor_y_in = req_data.y_pos;
                     state_in    = sftr_pkg::ST_RESP;
                  end
                  sftr_pkg::OP_READ_BYTE: begin
                     addr_in = AW'(req_data.byte_index);
                     if (32'(req_data.byte_index) < FB_BYTES) begin
                        state_in = sftr_pkg::ST_BYTE_RD;
                     end else begin
                        state_in = sftr_pkg::ST_RESP;
                     end
                  end
                  default: begin
                     state_in = sftr_pkg::ST_RESP;
                  end
               endcase
            end
         end

         sftr_pkg::ST_PIX_RD: begin
            mem_rd_en = 1'b1;
            state_in  = sftr_pkg::ST_PIX_WR;
         end

         sftr_pkg::ST_PIX_WR: begin
            mem_wr_en = 1'b1;
            if (req_ff.pixel_on) begin
               mem_wr_data = mem_rd_data | (8'd1 << req_ff.y_pos[2:0]);
            end else begin
               mem_wr_data = mem_rd_data & ~(8'd1 << req_ff.y_pos[2:0]);
            end
            state_in = sftr_pkg::ST_RESP;
         end

         sftr_pkg::ST_GLY_INIT: begin
            last_row_wide = 10'(cursor_y_ff)
                            + 10'(scale_ff) * 10'(sftr_pkg::GLYPH_ROWS) - 10'd1;
            if (last_row_wide > 10'(SCREEN_HEIGHT - 1)) begin
               last_row_wide = 10'(SCREEN_HEIGHT - 1);
            end
            last_row_in   = 8'(last_row_wide);
            first_py_in   = {1'b0, cursor_y_ff[7:3], 3'b000};
            py_base_in    = {1'b0, cursor_y_ff[7:3], 3'b000};
            first_page_in = AW'(32'(cursor_y_ff[7:3]) * SCREEN_WIDTH);
            page_addr_in  = AW'(32'(cursor_y_ff[7:3]) * SCREEN_WIDTH);
            col_x_in      = 9'(cursor_x_ff);
            gc_in         = '0;
            sub_in        = '0;
            if (32'(cursor_x_ff) >= SCREEN_WIDTH || 32'(cursor_y_ff) >= SCREEN_HEIGHT) begin
               state_in = sftr_pkg::ST_GLY_END;
            end else begin
               state_in = sftr_pkg::ST_GLY_RD;
            end
         end

         sftr_pkg::ST_GLY_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(page_addr_ff + AW'(col_x_ff));
            addr_in     = mem_rd_addr;
            win_in      = 8'(exp_pad >> win_shift);
            mask_in     = 8'(cov_pad >> win_shift) & h_mask;
            state_in    = sftr_pkg::ST_GLY_WR;
         end

         sftr_pkg::ST_GLY_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (mem_rd_data & ~mask_ff) | (win_ff & mask_ff);
            if (10'(py_base_ff) + 10'd8 <= 10'(last_row_ff)) begin
               py_base_in   = 9'(py_base_ff + 9'd8);
               page_addr_in = AW'(page_addr_ff + AW'(SCREEN_WIDTH));
               state_in     = sftr_pkg::ST_GLY_RD;
            end else if ((32'(gc_ff) == sftr_pkg::GLYPH_COLS - 1 &&
                          sub_ff == SW'(scale_ff - 1'b1)) ||
                         32'(col_x_ff) + 1 >= SCREEN_WIDTH) begin
               state_in = sftr_pkg::ST_GLY_END;
            end else begin
               // advance one pixel column, rewind to the first page
               col_x_in     = 9'(col_x_ff + 9'd1);
               py_base_in   = first_py_ff;
               page_addr_in = first_page_ff;
               if (sub_ff == SW'(scale_ff - 1'b1)) begin
                  sub_in = '0;
                  gc_in  = 3'(gc_ff + 3'd1);
               end else begin
                  sub_in = SW'(sub_ff + 1'b1);
               end
               state_in = sftr_pkg::ST_GLY_RD;
            end
         end

         sftr_pkg::ST_GLY_END: begin
            next_x = 10'(cursor_x_ff) + 10'(scale_ff) * 10'(sftr_pkg::GLYPH_COLS) + 10'd1;
            next_y = 10'(cursor_y_ff);
            if (next_x >= 10'(SCREEN_WIDTH)) begin
               next_x = '0;
               next_y = 10'(cursor_y_ff)
                        + 10'(scale_ff) * 10'(sftr_pkg::GLYPH_ROWS) + 10'd1;
            end
            if (next_y >= 10'(SCREEN_HEIGHT)) begin
               next_x = '0;
               next_y = '0;
            end
            cursor_x_in = 8'(next_x);
            cursor_y_in = 8'(next_y);
            state_in    = sftr_pkg::ST_RESP;
         end

         sftr_pkg::ST_BYTE_RD: begin
            mem_rd_en = 1'b1;
            state_in  = sftr_pkg::ST_BYTE_WAIT;
         end

         sftr_pkg::ST_BYTE_WAIT: begin
            res_rd_in = mem_rd_data;
            state_in  = sftr_pkg::ST_RESP;
         end

         sftr_pkg::ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_data  = res_rd_ff;
               rsp_in.cursor_col = cursor_x_ff;
               rsp_in.cursor_row = cursor_y_ff;
               state_in          = sftr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sftr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sftr_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         clr_addr_ff  <= clr_addr_in;
         clr_resp_ff  <= clr_resp_in;
      end
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      res_rd_ff     <= res_rd_in;
      addr_ff       <= addr_in;
      scale_ff      <= scale_in;
      glyph_ff      <= glyph_in;
      gc_ff         <= gc_in;
      sub_ff        <= sub_in;
      col_x_ff      <= col_x_in;
      py_base_ff    <= py_base_in;
      first_py_ff   <= first_py_in;
      last_row_ff   <= last_row_in;
      page_addr_ff  <= page_addr_in;
      first_page_ff <= first_page_in;
      win_ff        <= win_in;
      mask_ff       <= mask_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
